/* rtl/hts_pkg.sv */
// Shared types and constants of the Huffman tree stream decoder.
package hts_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned JOB_BITS    = 2 * BYTE_W;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned QDEPTH      = 2;

  localparam logic [2:0]       TRL_EXT_MAX = 3'd5;
  localparam logic [CNT_W-1:0] BYTE_BITS   = 5'd8;
  localparam logic [3:0]       SYM_BITS    = 4'd8;

  typedef enum logic [1:0] {
    PH_TREE,
    PH_SYM,
    PH_WALK,
    PH_HALT
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIT,
    S_POP,
    S_RLOAD,
    S_RCAP,
    S_WCHK,
    S_FLUSH
  } state_e;

  typedef struct packed {
    logic [JOB_BITS-1:0] data;
    logic [CNT_W-1:0]    count;
    logic                trailer;
  } job_t;

endpackage

/* rtl/huffman_tree_stream_decoder.sv */
// Top level of the Huffman tree stream decoder.
// Encoded bytes enter on the slave stream, MSB first; the stream opens with a preorder
// Huffman tree, then carries the coded symbols, and ends with a trailer byte flagged by
// tlast whose low three bits n give the number of bits still to decode: n plus eight when
// n is at most 5, else n. A byte is decoded only once the next byte has arrived, and each
// decoded symbol leaves on the master stream, with tlast marking the last symbol caused by
// one input transaction. A front end keeps the lookahead byte and turns bytes into bit jobs,
// a two-entry queue holds them, and the decode engine works one bit at a time against a node
// store with a registered read port. A tree bit that takes its parent from the stack memory
// first reads it in a pop state, every walk bit waits on the node-store read (unless the
// whole tree is a single leaf), each job passes a start and a finish state, and the bit that
// completes the tree is followed by a load of the root node; the trailer transaction carries
// up to 13 bits.
module huffman_tree_stream_decoder
  import hts_pkg::*;
#(
  parameter int unsigned NODE_COUNT  = 512,
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [BYTE_W-1:0] s_axis_tdata,  // byte_in [7:0]
  input  logic              s_axis_tlast,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [BYTE_W-1:0] m_axis_tdata,  // symbol [7:0]
  output logic              m_axis_tlast
);

  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_job, pop_job;

  hts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .s_last_i    (s_axis_tlast),
    .push_valid_o(push_valid),
    .push_job_o  (push_job),
    .push_ready_i(push_ready)
  );

  hts_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_data_i (push_job),
    .push_ready_o(push_ready),
    .pop_valid_o (pop_valid),
    .pop_data_o  (pop_job),
    .pop_ready_i (pop_ready)
  );

  hts_back #(
    .NODE_COUNT (NODE_COUNT),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(pop_valid),
    .job_i      (pop_job),
    .job_ready_o(pop_ready),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata),
    .m_last_o   (m_axis_tlast)
  );

endmodule

/* rtl/hts_front.sv */
// Front end: lookahead byte, trailer handling and bit job generation.
module hts_front
  import hts_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic [BYTE_W-1:0] s_data_i,
  input  logic              s_last_i,
  output logic              push_valid_o,
  output job_t              push_job_o,
  input  logic              push_ready_i
);

  logic [BYTE_W-1:0] held_q, held_d;
  logic              have_q, have_d;
  logic              trl_seen_q, trl_seen_d;
  logic              accept;
  logic [2:0]        n;

  assign s_ready_o = push_ready_i;
  assign accept    = s_valid_i && push_ready_i;
  assign n         = s_data_i[2:0];

  always_comb begin
    held_d       = held_q;
    have_d       = have_q;
    trl_seen_d   = trl_seen_q;
    push_valid_o = 1'b0;
    push_job_o   = '{data: {held_q, {BYTE_W{1'b0}}}, count: BYTE_BITS, trailer: 1'b0};
    if (accept && !trl_seen_q) begin
      if (!have_q) begin
        if (s_last_i) begin
          trl_seen_d = 1'b1;
        end else begin
          held_d = s_data_i;
          have_d = 1'b1;
        end
      end else if (s_last_i) begin
        push_valid_o       = 1'b1;
        push_job_o.data    = {held_q, s_data_i};
        push_job_o.count   = (n <= TRL_EXT_MAX) ? ({2'b00, n} + BYTE_BITS) : {2'b00, n};
        push_job_o.trailer = 1'b1;
        trl_seen_d         = 1'b1;
        have_d             = 1'b0;
      end else begin
        push_valid_o = 1'b1;
        held_d       = s_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q     <= 1'b0;
      trl_seen_q <= 1'b0;
    end else begin
      have_q     <= have_d;
      trl_seen_q <= trl_seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule

/* rtl/hts_queue.sv */
// Short job queue between the front end and the decode engine.
module hts_queue
  import hts_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  job_t push_data_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output job_t pop_data_o,
  input  logic pop_ready_i
);

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  job_t          slots_q [QDEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign push_ready_o = (count_q != CW'(QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slots_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/hts_back.sv */
// Decode engine: tree rebuild, symbol walk and result output register.
module hts_back
  import hts_pkg::*;
#(
  parameter int unsigned NODE_COUNT  = 512,
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  job_t              job_i,
  output logic              job_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output logic [BYTE_W-1:0] m_data_o,
  output logic              m_last_o
);

  localparam int unsigned NW = $clog2(NODE_COUNT);
  localparam int unsigned FW = $clog2(NODE_COUNT + 1);
  localparam int unsigned LW = (NW > BYTE_W) ? NW : BYTE_W;
  localparam int unsigned SW = $clog2(STACK_DEPTH);
  localparam int unsigned TW = $clog2(STACK_DEPTH + 1);

  logic [LW:0]   node_l  [NODE_COUNT];
  logic [NW-1:0] node_r  [NODE_COUNT];
  logic [NW-1:0] stack_m [STACK_DEPTH];

  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [FW-1:0]     nfree_q, nfree_d;
  logic [TW-1:0]     top_q, top_d;
  logic [TW-1:0]     mcnt_q, mcnt_d;
  logic              pl_valid_q, pl_valid_d;
  logic [NW-1:0]     pl_idx_q, pl_idx_d;
  logic              root_leaf_q, root_leaf_d;
  logic [BYTE_W-1:0] sym_q, sym_d;
  logic [3:0]        symcnt_q, symcnt_d;
  logic [NW-1:0]     cur_l_q, cur_l_d, cur_r_q, cur_r_d;
  logic [NW-1:0]     root_l_q, root_l_d, root_r_q, root_r_d;
  logic [JOB_BITS-1:0] sh_q, sh_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              trl_q, trl_d;
  logic              pend_valid_q, pend_valid_d;
  logic [BYTE_W-1:0] pend_sym_q, pend_sym_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_sym_q;
  logic              out_last_q;

  logic [LW:0]   nl_rd_q;
  logic [NW-1:0] nr_rd_q;
  logic [NW-1:0] st_rd_q;

  logic          nl_we, nr_we, st_we, nl_re, st_re;
  logic [NW-1:0] nl_waddr, nr_waddr, n_raddr, nr_wdata, st_wdata;
  logic [LW:0]   nl_wdata;
  logic [SW-1:0] st_waddr, st_raddr;

  logic          out_push, out_push_last;
  logic [BYTE_W-1:0] out_push_sym;

  logic          cur_bit, have_bit, last_bit, out_ok;
  logic          tree_full, no_parent, need_pop, wchk_leaf, wchk_stall, flush_stall;
  logic          tree_go, from_mem;
  logic [NW-1:0] idx, leaf_idx;
  logic [FW-1:0] leaf_full;
  logic [TW-1:0] top_after, mcnt_after, mcnt_dec;
  logic [TW:0]   top_plus2;

  assign cur_bit     = sh_q[JOB_BITS-1];
  assign have_bit    = (cnt_q != '0);
  assign last_bit    = trl_q && (cnt_q == CNT_W'(1));
  assign out_ok      = !out_valid_q || m_ready_i;
  assign tree_full   = (nfree_q >= FW'(NODE_COUNT));
  assign no_parent   = (nfree_q != '0) && (top_q == '0);
  assign need_pop    = (nfree_q != '0) && !pl_valid_q;
  assign wchk_leaf   = nl_rd_q[LW];
  assign wchk_stall  = wchk_leaf && !last_bit && pend_valid_q && !out_ok;
  assign flush_stall = pend_valid_q && !out_ok;
  assign idx         = nfree_q[NW-1:0];
  assign leaf_full   = nfree_q - 1'b1;
  assign leaf_idx    = leaf_full[NW-1:0];
  assign mcnt_dec    = mcnt_q - 1'b1;
  assign st_raddr    = mcnt_dec[SW-1:0];
  assign job_ready_o = (state_q == S_IDLE);

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_sym_q;
  assign m_last_o  = out_last_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          state_d = S_BIT;
        end
      end
      S_BIT: begin
        if (!have_bit) begin
          state_d = S_FLUSH;
        end else begin
          case (phase_q)
            PH_TREE: begin
              if (!tree_full && !no_parent && need_pop) begin
                state_d = S_POP;
              end
            end
            PH_SYM: begin
              if ((symcnt_q == 4'd1) && (top_q == '0)) begin
                state_d = S_RLOAD;
              end
            end
            PH_WALK: begin
              if (!root_leaf_q) begin
                state_d = S_WCHK;
              end
            end
            default: state_d = S_BIT;
          endcase
        end
      end
      S_POP:   state_d = S_BIT;
      S_RLOAD: state_d = S_RCAP;
      S_RCAP:  state_d = S_BIT;
      S_WCHK: begin
        if (!wchk_stall) begin
          state_d = S_BIT;
        end
      end
      S_FLUSH: begin
        if (!flush_stall) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    phase_d      = phase_q;
    nfree_d      = nfree_q;
    top_d        = top_q;
    mcnt_d       = mcnt_q;
    pl_valid_d   = pl_valid_q;
    pl_idx_d     = pl_idx_q;
    root_leaf_d  = root_leaf_q;
    sym_d        = sym_q;
    symcnt_d     = symcnt_q;
    cur_l_d      = cur_l_q;
    cur_r_d      = cur_r_q;
    root_l_d     = root_l_q;
    root_r_d     = root_r_q;
    sh_d         = sh_q;
    cnt_d        = cnt_q;
    trl_d        = trl_q;
    pend_valid_d = pend_valid_q;
    pend_sym_d   = pend_sym_q;
    nl_we        = 1'b0;
    nr_we        = 1'b0;
    st_we        = 1'b0;
    nl_re        = 1'b0;
    st_re        = 1'b0;
    nl_waddr     = '0;
    nl_wdata     = '0;
    nr_waddr     = '0;
    nr_wdata     = '0;
    st_waddr     = '0;
    st_wdata     = '0;
    n_raddr      = '0;
    out_push     = 1'b0;
    out_push_sym = pend_sym_q;
    out_push_last = 1'b0;
    tree_go      = 1'b0;
    from_mem     = 1'b0;
    top_after    = (nfree_q != '0) ? top_q - 1'b1 : top_q;
    mcnt_after   = mcnt_q;
    top_plus2    = '0;

    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          sh_d  = job_i.data;
          cnt_d = job_i.count;
          trl_d = job_i.trailer;
        end
      end
      S_BIT: begin
        if (have_bit) begin
          case (phase_q)
            PH_TREE: begin
              if (tree_full || no_parent) begin
                phase_d = PH_HALT;
                sh_d    = {sh_q[JOB_BITS-2:0], 1'b0};
                cnt_d   = cnt_q - 1'b1;
              end else if (need_pop) begin
                st_re = 1'b1;
              end else begin
                tree_go = 1'b1;
              end
            end
            PH_SYM: begin
              sym_d    = {sym_q[BYTE_W-2:0], cur_bit};
              symcnt_d = symcnt_q - 1'b1;
              sh_d     = {sh_q[JOB_BITS-2:0], 1'b0};
              cnt_d    = cnt_q - 1'b1;
              if (symcnt_q == 4'd1) begin
                nl_we    = 1'b1;
                nl_waddr = leaf_idx;
                nl_wdata = {1'b1, LW'(sym_d)};
                phase_d  = (top_q == '0) ? PH_WALK : PH_TREE;
              end
            end
            PH_WALK: begin
              if (root_leaf_q) begin
                sh_d  = {sh_q[JOB_BITS-2:0], 1'b0};
                cnt_d = cnt_q - 1'b1;
              end else begin
                nl_re   = 1'b1;
                n_raddr = cur_bit ? cur_r_q : cur_l_q;
              end
            end
            default: begin
              sh_d  = {sh_q[JOB_BITS-2:0], 1'b0};
              cnt_d = cnt_q - 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        tree_go  = 1'b1;
        from_mem = 1'b1;
      end
      S_RLOAD: begin
        nl_re   = 1'b1;
        n_raddr = '0;
      end
      S_RCAP: begin
        root_l_d = nl_rd_q[NW-1:0];
        root_r_d = nr_rd_q;
        cur_l_d  = nl_rd_q[NW-1:0];
        cur_r_d  = nr_rd_q;
      end
      S_WCHK: begin
        if (!wchk_stall) begin
          sh_d  = {sh_q[JOB_BITS-2:0], 1'b0};
          cnt_d = cnt_q - 1'b1;
          if (wchk_leaf) begin
            if (!last_bit) begin
              if (pend_valid_q) begin
                out_push = 1'b1;
              end
              pend_valid_d = 1'b1;
              pend_sym_d   = nl_rd_q[BYTE_W-1:0];
              cur_l_d      = root_l_q;
              cur_r_d      = root_r_q;
            end
          end else begin
            cur_l_d = nl_rd_q[NW-1:0];
            cur_r_d = nr_rd_q;
          end
        end
      end
      S_FLUSH: begin
        if (pend_valid_q && out_ok) begin
          out_push      = 1'b1;
          out_push_last = 1'b1;
          pend_valid_d  = 1'b0;
        end
      end
      default: begin
        sh_d = sh_q;
      end
    endcase

    if (tree_go) begin
      mcnt_after = from_mem ? mcnt_q - 1'b1 : mcnt_q;
      sh_d       = {sh_q[JOB_BITS-2:0], 1'b0};
      cnt_d      = cnt_q - 1'b1;
      if (nfree_q != '0) begin
        if (from_mem) begin
          nr_we    = 1'b1;
          nr_waddr = st_rd_q;
          nr_wdata = idx;
        end else begin
          nl_we    = 1'b1;
          nl_waddr = pl_idx_q;
          nl_wdata = {1'b0, LW'(idx)};
        end
        pl_valid_d = 1'b0;
      end
      if (cur_bit) begin
        phase_d  = PH_SYM;
        symcnt_d = SYM_BITS;
        sym_d    = '0;
        if (nfree_q == '0) begin
          root_leaf_d = 1'b1;
        end
        top_d   = top_after;
        mcnt_d  = mcnt_after;
        nfree_d = nfree_q + 1'b1;
      end else begin
        top_plus2 = {1'b0, top_after} + (TW + 1)'(2);
        if (top_plus2 > (TW + 1)'(STACK_DEPTH)) begin
          phase_d = PH_HALT;
        end else begin
          st_we      = 1'b1;
          st_waddr   = mcnt_after[SW-1:0];
          st_wdata   = idx;
          mcnt_d     = mcnt_after + 1'b1;
          pl_idx_d   = idx;
          pl_valid_d = 1'b1;
          top_d      = top_plus2[TW-1:0];
          nfree_d    = nfree_q + 1'b1;
        end
      end
    end
  end

  assign out_valid_d = out_push ? 1'b1 : (m_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      phase_q      <= PH_TREE;
      nfree_q      <= '0;
      top_q        <= '0;
      mcnt_q       <= '0;
      pl_valid_q   <= 1'b0;
      root_leaf_q  <= 1'b0;
      symcnt_q     <= '0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      nfree_q      <= nfree_d;
      top_q        <= top_d;
      mcnt_q       <= mcnt_d;
      pl_valid_q   <= pl_valid_d;
      root_leaf_q  <= root_leaf_d;
      symcnt_q     <= symcnt_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pl_idx_q   <= pl_idx_d;
    sym_q      <= sym_d;
    cur_l_q    <= cur_l_d;
    cur_r_q    <= cur_r_d;
    root_l_q   <= root_l_d;
    root_r_q   <= root_r_d;
    sh_q       <= sh_d;
    trl_q      <= trl_d;
    pend_sym_q <= pend_sym_d;
    if (out_push) begin
      out_sym_q  <= out_push_sym;
      out_last_q <= out_push_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (nl_we) begin
      node_l[nl_waddr] <= nl_wdata;
    end
    if (nr_we) begin
      node_r[nr_waddr] <= nr_wdata;
    end
    if (nl_re) begin
      nl_rd_q <= node_l[n_raddr];
      nr_rd_q <= node_r[n_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      stack_m[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      st_rd_q <= stack_m[st_raddr];
    end
  end

endmodule

/* rtl/hts_checker.sv */
// Port-level checker of the Huffman tree stream decoder and its bind.
module hts_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  logic [1:0] in_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q <= 2'd0;
    end else if (s_axis_tvalid && s_axis_tready && !s_axis_tlast && (in_cnt_q != 2'd2)) begin
      in_cnt_q <= in_cnt_q + 2'd1;
    end else if (s_axis_tvalid && s_axis_tready && s_axis_tlast && (in_cnt_q == 2'd1)) begin
      in_cnt_q <= 2'd2;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("Output valid dropped before the transaction completed.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("Stalled output payload changed.");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("Output valid asserted during reset.");

  a_need_two_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (in_cnt_q == 2'd2))
    else $error("Symbol produced before two bytes were taken.");

endmodule

bind huffman_tree_stream_decoder hts_checker u_hts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);

/* tb/sv/huffman_tree_stream_decoder_chk.sv */
// Checker that predicts the decoded symbol stream and compares it with the block's output.
module huffman_tree_stream_decoder_chk
  import hts_pkg::*;
#(
  parameter int unsigned NODE_COUNT  = 512,
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [BYTE_W-1:0] s_axis_tdata,
  input  logic              s_axis_tlast,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [BYTE_W-1:0] m_axis_tdata,
  input  logic              m_axis_tlast,
  output int                mismatches_o,
  output int                outstanding_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_SYMS   = 13;
  localparam int unsigned MAX_REPORT = 10;
  localparam int unsigned LEAF_BIT   = 18;

  typedef struct packed {
    logic [BYTE_W-1:0] sym;
    logic              last;
  } sym_beat_t;

  sym_beat_t         decoded_syms[$];
  sym_beat_t         step_syms[$];

  logic [18:0]       node_mem[NODE_COUNT];
  logic [9:0]        slot_mem[STACK_DEPTH];
  logic [BYTE_W-1:0] held_byte;
  bit                held_valid;
  int unsigned       slot_top;
  int unsigned       free_node;
  phase_e            dec_phase;
  logic [7:0]        sym_acc;
  int unsigned       sym_left;
  int unsigned       walk_at;
  int unsigned       bits_left;
  bit                trailer_done;

  function automatic void clear_decoder();
    foreach (node_mem[i]) node_mem[i] = '0;
    foreach (slot_mem[i]) slot_mem[i] = '0;
    held_byte    = '0;
    held_valid   = 1'b0;
    slot_top     = 0;
    free_node    = 0;
    dec_phase    = PH_TREE;
    sym_acc      = '0;
    sym_left     = 0;
    walk_at      = 0;
    bits_left    = 0;
    trailer_done = 1'b0;
  endfunction

  function automatic void add_tree_node(input bit b);
    int unsigned idx;
    logic [9:0]  slot;
    idx = free_node;
    if (idx >= NODE_COUNT) begin
      dec_phase = PH_HALT;
      return;
    end
    if (idx != 0) begin
      if (slot_top == 0 || slot_top > STACK_DEPTH) begin
        dec_phase = PH_HALT;
        return;
      end
      slot_top--;
      slot = slot_mem[slot_top];
      if (slot[0]) node_mem[slot[9:1]][8:0] = idx[8:0];
      else node_mem[slot[9:1]][17:9] = idx[8:0];
    end
    if (b) begin
      node_mem[idx] = 19'(1) << LEAF_BIT;
      dec_phase     = PH_SYM;
      sym_left      = 8;
      sym_acc       = '0;
    end else begin
      node_mem[idx] = '0;
      if (slot_top + 2 > STACK_DEPTH) begin
        dec_phase = PH_HALT;
        return;
      end
      slot_mem[slot_top] = {idx[8:0], 1'b1};
      slot_top++;
      slot_mem[slot_top] = {idx[8:0], 1'b0};
      slot_top++;
    end
    free_node = idx + 1;
  endfunction

  function automatic void decode_bit(input bit b);
    logic [18:0] cur;
    logic [18:0] nxt;
    int unsigned child;
    if (trailer_done) begin
      if (bits_left == 0) return;
      bits_left--;
    end
    case (dec_phase)
      PH_TREE: begin
        add_tree_node(b);
      end
      PH_SYM: begin
        sym_acc = {sym_acc[6:0], b};
        if (sym_left > 0) sym_left--;
        if (sym_left == 0) begin
          if (free_node - 1 < NODE_COUNT)
            node_mem[free_node-1] = (19'(1) << LEAF_BIT) | (19'(sym_acc) << 9);
          if (slot_top == 0) begin
            dec_phase = PH_WALK;
            walk_at   = 0;
          end else begin
            dec_phase = PH_TREE;
          end
        end
      end
      PH_WALK: begin
        if (node_mem[0][LEAF_BIT]) return;
        cur   = node_mem[walk_at];
        child = b ? cur[8:0] : cur[17:9];
        nxt   = node_mem[child];
        if (nxt[LEAF_BIT]) begin
          if (trailer_done && bits_left == 0) return;
          if (step_syms.size() < MAX_SYMS) step_syms.push_back('{sym: nxt[16:9], last: 1'b0});
          walk_at = 0;
        end else begin
          walk_at = child;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    for (int i = 7; i >= 0; i--) decode_bit(b[i]);
  endfunction

  // Works out the symbols caused by one input transaction and queues them.
  function automatic void predict_symbols(input logic [7:0] b, input logic fin);
    logic [7:0] prev;
    logic [2:0] n;
    step_syms.delete();
    if (trailer_done) return;
    if (!held_valid) begin
      if (fin) begin
        trailer_done = 1'b1;
        bits_left    = 0;
      end else begin
        held_byte  = b;
        held_valid = 1'b1;
      end
      return;
    end
    prev = held_byte;
    if (fin) begin
      n            = b[2:0];
      bits_left    = (n <= TRL_EXT_MAX) ? n + 8 : n;
      trailer_done = 1'b1;
      held_valid   = 1'b0;
      decode_byte(prev);
      decode_byte(b);
    end else begin
      held_byte = b;
      decode_byte(prev);
    end
    if (step_syms.size() > 0) step_syms[step_syms.size()-1].last = 1'b1;
    foreach (step_syms[i]) decoded_syms.push_back(step_syms[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sym_beat_t want;
    if (!rst_ni) begin
      clear_decoder();
      decoded_syms.delete();
      mismatches_o  = 0;
      outstanding_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (decoded_syms.size() == 0) begin
          if (mismatches_o < MAX_REPORT)
            $display("%0t: unexpected symbol %02h last %b", $realtime, m_axis_tdata,
                     m_axis_tlast);
          mismatches_o++;
        end else begin
          want = decoded_syms.pop_front();
          if (m_axis_tdata !== want.sym || m_axis_tlast !== want.last) begin
            if (mismatches_o < MAX_REPORT)
              $display("%0t: symbol expected %02h last %b, got %02h last %b", $realtime,
                       want.sym, want.last, m_axis_tdata, m_axis_tlast);
            mismatches_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_symbols(s_axis_tdata, s_axis_tlast);
      outstanding_o = decoded_syms.size();
    end
  end

endmodule

/* tb/sv/huffman_tree_stream_decoder_tb.sv */
// Top of the testbench: clock, reset, stream stimulus and final verdict for the decoder.
module huffman_tree_stream_decoder_tb
  import hts_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BODY_BYTES = 450;
  localparam int unsigned DRAIN_WAIT = 100;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [BYTE_W-1:0] s_axis_tdata;
  logic              s_axis_tlast;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [BYTE_W-1:0] m_axis_tdata;
  logic              m_axis_tlast;
  int                mismatches;
  int                outstanding;
  int unsigned       idle_mode;

  huffman_tree_stream_decoder DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  huffman_tree_stream_decoder_chk u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= !((idle_mode == 2 && $urandom_range(0, 99) < 71) ||
                         (idle_mode == 3 && $urandom_range(0, 99) < 11));
    end
  end

  // Sends one byte; the idle pattern depends on the current phase.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ((idle_mode == 1 && $urandom_range(0, 99) < 71) ||
           (idle_mode == 3 && $urandom_range(0, 99) < 11)) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  initial begin
    bit          code_bits[$];
    logic [7:0]  body[$];
    logic [7:0]  b;
    logic [7:0]  sym;
    int unsigned leaves;
    int unsigned open_slots;
    int unsigned inner_left;
    int unsigned leaves_left;
    int unsigned leaf_no;
    bit          take_leaf;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    idle_mode     = 0;

    // Random full tree in preorder; the first two leaves carry the symbol extremes.
    leaves      = ($urandom_range(0, 7) == 0) ? 256 : $urandom_range(2, 48);
    open_slots  = 1;
    inner_left  = leaves - 1;
    leaves_left = leaves;
    leaf_no     = 0;
    while (leaves_left > 0) begin
      if (inner_left == 0) take_leaf = 1'b1;
      else if (open_slots == 1) take_leaf = 1'b0;
      else take_leaf = 1'($urandom_range(0, 1));
      if (take_leaf) begin
        sym = (leaf_no == 0) ? 8'h00 : (leaf_no == 1) ? 8'hFF : 8'($urandom_range(0, 255));
        code_bits.push_back(1'b1);
        for (int i = 7; i >= 0; i--) code_bits.push_back(sym[i]);
        open_slots--;
        leaves_left--;
        leaf_no++;
      end else begin
        code_bits.push_back(1'b0);
        open_slots++;
        inner_left--;
      end
    end
    // All-left, all-right and alternating paths first, then random code bits.
    for (int i = 0; i < 16; i++) code_bits.push_back(1'b0);
    for (int i = 0; i < 16; i++) code_bits.push_back(1'b1);
    for (int i = 0; i < 16; i++) code_bits.push_back(i[0]);
    while (code_bits.size() < 8 * BODY_BYTES) code_bits.push_back(1'($urandom_range(0, 1)));
    for (int i = 0; i < BODY_BYTES; i++) begin
      for (int j = 0; j < 8; j++) b[7-j] = code_bits[8*i+j];
      body.push_back(b);
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (body[i]) begin
      idle_mode = (i / 30) % 4;
      send_byte(body[i], 1'b0);
    end
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    // The decoder ignores everything after the trailer.
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    s_axis_tvalid <= 1'b0;

    wait (outstanding == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
